[rtl/roa_pkg.sv]
// ----------------------------------------------------------------------------
// roa_pkg
// shared widths, pipeline record and arctangent table for the orientation
// angle pipeline
// ----------------------------------------------------------------------------
package roa_pkg;

	// sample and product widths
	localparam int SAMPLE_WIDTH  = 16;
	localparam int CORDIC_STAGES = 24;
	localparam int NUM_CELLS     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int PW            = 2 * SAMPLE_WIDTH;      // one product
	localparam int CW            = PW + 1;                // cos / sin sums
	localparam int XW            = PW + 3;                // cordic x / y with gain
	localparam int ZW            = 26;                    // angle in 1/65536 degree
	localparam int DW            = ZW + 2;                // 180 - angle before wrap
	localparam int OUT_W         = 17;
	localparam int CFG_W         = 32;
	localparam int CMP_W         = (PW > CFG_W) ? PW : CFG_W;
	localparam int CELL_IDX_W    = 5;
	localparam int ADDR_W        = 3;

	localparam logic [CFG_W-1:0] MIN_NORM_RESET = CFG_W'(1);

	// angle constants
	localparam logic signed [ZW-1:0] QUARTER_Q16 = ZW'(90 * 65536);
	localparam logic signed [DW-1:0] HALF_Q16    = DW'(180 * 65536);
	localparam logic signed [DW-1:0] FULL_Q16    = DW'(360 * 65536);
	localparam logic [DW-1:0]        ROUND_Q16   = DW'(128);
	localparam logic [DW-1:0]        FULL_Q8     = DW'(92160);
	localparam logic [OUT_W-1:0]     HALF_Q8     = OUT_W'(46080);

	// record handed from cell to cell
	typedef struct packed {
		logic                 vld;
		logic                 degen;
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// atan(2^-i) in degrees times 65536, rounded
	function automatic logic signed [ZW-1:0] atan_q16(input logic [CELL_IDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = ZW'(2949120);
			5'd1:    v = ZW'(1740967);
			5'd2:    v = ZW'(919879);
			5'd3:    v = ZW'(466945);
			5'd4:    v = ZW'(234379);
			5'd5:    v = ZW'(117304);
			5'd6:    v = ZW'(58666);
			5'd7:    v = ZW'(29335);
			5'd8:    v = ZW'(14668);
			5'd9:    v = ZW'(7334);
			5'd10:   v = ZW'(3667);
			5'd11:   v = ZW'(1833);
			5'd12:   v = ZW'(917);
			5'd13:   v = ZW'(458);
			5'd14:   v = ZW'(229);
			5'd15:   v = ZW'(115);
			5'd16:   v = ZW'(57);
			5'd17:   v = ZW'(29);
			5'd18:   v = ZW'(14);
			5'd19:   v = ZW'(7);
			5'd20:   v = ZW'(4);
			5'd21:   v = ZW'(2);
			5'd22:   v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/roa_front.sv]
// ----------------------------------------------------------------------------
// roa_front
// products, norms, degenerate test and quadrant pre-rotation (three stages)
// ----------------------------------------------------------------------------
module roa_front
	import roa_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [SAMPLE_WIDTH-1:0] local_y,
	input  logic signed [SAMPLE_WIDTH-1:0] local_z,
	input  logic signed [SAMPLE_WIDTH-1:0] neighbor_y,
	input  logic signed [SAMPLE_WIDTH-1:0] neighbor_z,
	input  logic [CFG_W-1:0]               min_norm,
	output cordic_t                        out
);

	logic                 vld_s1, vld_s2;
	logic signed [PW-1:0] ly2_s1, lz2_s1, ny2_s1, nz2_s1;
	logic signed [PW-1:0] lyny_s1, lznz_s1, lynz_s1, lzny_s1;
	logic [PW-1:0]        norm_l_s2, norm_n_s2;
	logic signed [CW-1:0] c_s2, s_s2;
	cordic_t              rec_s3;

	logic signed [XW-1:0] cx, cy, nx, ny_w;
	logic signed [ZW-1:0] nz_w;
	logic                 degen_w;

	// stage 1: products
	always_ff @(posedge clk) begin
		ly2_s1  <= local_y * local_y;
		lz2_s1  <= local_z * local_z;
		ny2_s1  <= neighbor_y * neighbor_y;
		nz2_s1  <= neighbor_z * neighbor_z;
		lyny_s1 <= local_y * neighbor_y;
		lznz_s1 <= local_z * neighbor_z;
		lynz_s1 <= local_y * neighbor_z;
		lzny_s1 <= local_z * neighbor_y;
	end

	// stage 2: norms, cos and sin
	always_ff @(posedge clk) begin
		norm_l_s2 <= PW'(unsigned'(ly2_s1)) + PW'(unsigned'(lz2_s1));
		norm_n_s2 <= PW'(unsigned'(ny2_s1)) + PW'(unsigned'(nz2_s1));
		c_s2      <= CW'(lznz_s1) - CW'(lyny_s1);
		s_s2      <= CW'(lynz_s1) + CW'(lzny_s1);
	end

	// stage 3: threshold and pre-rotation by +-90 degrees
	always_comb begin
		degen_w = (CMP_W'(norm_l_s2) < CMP_W'(min_norm)) ||
		          (CMP_W'(norm_n_s2) < CMP_W'(min_norm));
		cx   = XW'(c_s2);
		cy   = XW'(s_s2);
		nx   = cx;
		ny_w = cy;
		nz_w = '0;
		if (cx[XW-1]) begin
			if (!cy[XW-1]) begin
				nx   = cy;
				ny_w = -cx;
				nz_w = QUARTER_Q16;
			end else begin
				nx   = -cy;
				ny_w = cx;
				nz_w = -QUARTER_Q16;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			rec_s3 <= '0;
		end else begin
			vld_s1       <= in_vld;
			vld_s2       <= vld_s1;
			rec_s3.vld   <= vld_s2;
			rec_s3.degen <= degen_w;
			rec_s3.zero  <= (c_s2 == '0) && (s_s2 == '0);
			rec_s3.x     <= nx;
			rec_s3.y     <= ny_w;
			rec_s3.z     <= nz_w;
		end
	end

	assign out = rec_s3;

endmodule

[rtl/roa_cell.sv]
// ----------------------------------------------------------------------------
// roa_cell
// one cordic vectoring micro-rotation, registered
// ----------------------------------------------------------------------------
module roa_cell
	import roa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CELL_IDX_W-1:0] idx,
	input  cordic_t               in,
	output cordic_t               out
);

	cordic_t              out_q;
	logic signed [XW-1:0] dx, dy;
	logic                 y_pos;

	// floor shift of the neighbor coordinate
	assign dx    = in.y >>> idx;
	assign dy    = in.x >>> idx;
	assign y_pos = !in.y[XW-1] && (in.y != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q.vld   <= in.vld;
			out_q.degen <= in.degen;
			out_q.zero  <= in.zero;
			if (y_pos) begin
				out_q.x <= in.x + dx;
				out_q.y <= in.y - dy;
				out_q.z <= in.z + atan_q16(idx);
			end else begin
				out_q.x <= in.x - dx;
				out_q.y <= in.y + dy;
				out_q.z <= in.z - atan_q16(idx);
			end
		end
	end

	assign out = out_q;

endmodule

[rtl/roa_back.sv]
// ----------------------------------------------------------------------------
// roa_back
// 180 minus angle, wrap into one turn, round to 1/256 degree (two stages)
// ----------------------------------------------------------------------------
module roa_back
	import roa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cordic_t          in,
	output logic             done,
	output logic [OUT_W-1:0] angle_deg_q8,
	output logic             degenerate
);

	logic                 vld_s1, vld_s2;
	logic                 degen_s1;
	logic [DW-1:0]        d_s1;
	logic [OUT_W-1:0]     angle_s2;
	logic                 degen_s2;

	logic signed [DW-1:0] d_raw, d_wrap;
	logic [DW-1:0]        q_raw, q_wrap;

	// both cos and sin zero: angle taken as zero
	always_comb begin
		d_raw = HALF_Q16 - (in.zero ? DW'(0) : DW'(in.z));
		if (d_raw < 0) begin
			d_wrap = d_raw + FULL_Q16;
		end else if (d_raw >= FULL_Q16) begin
			d_wrap = d_raw - FULL_Q16;
		end else begin
			d_wrap = d_raw;
		end
	end

	always_ff @(posedge clk) begin
		d_s1     <= unsigned'(d_wrap);
		degen_s1 <= in.degen;
	end

	// round half up, a full turn wraps to zero
	always_comb begin
		q_raw  = (d_s1 + ROUND_Q16) >> 8;
		q_wrap = (q_raw >= FULL_Q8) ? (q_raw - FULL_Q8) : q_raw;
	end

	always_ff @(posedge clk) begin
		angle_s2 <= degen_s1 ? HALF_Q8 : OUT_W'(q_wrap);
		degen_s2 <= degen_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in.vld;
			vld_s2 <= vld_s1;
		end
	end

	assign done         = vld_s2;
	assign angle_deg_q8 = angle_s2;
	assign degenerate   = degen_s2;

endmodule

[rtl/relative_orientation_angle.sv]
// ----------------------------------------------------------------------------
// relative_orientation_angle
// relative angle of two gravity vectors in their y-z plane by cordic atan2
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle, busy is always low
// the pipeline is fixed length: three front stages, one cell per micro-rotation,
// two back stages; the receiver cannot stall, so done is a one-cycle strobe
// reset clears all valid flags and sets min_norm_squared to 1
// ----------------------------------------------------------------------------
module relative_orientation_angle
	import roa_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           start,
	output logic                           busy,
	input  logic signed [SAMPLE_WIDTH-1:0] local_y,
	input  logic signed [SAMPLE_WIDTH-1:0] local_z,
	input  logic signed [SAMPLE_WIDTH-1:0] neighbor_y,
	input  logic signed [SAMPLE_WIDTH-1:0] neighbor_z,
	// result channel
	output logic                           done,
	output logic [OUT_W-1:0]               angle_deg_q8,
	output logic                           degenerate,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_W-1:0]              paddr,
	input  logic [CFG_W-1:0]               pwdata,
	output logic [CFG_W-1:0]               prdata,
	output logic                           pready
);

	logic [CFG_W-1:0] min_norm_q;
	logic             in_vld;
	logic             reg_sel;
	cordic_t          chain [0:NUM_CELLS];

	// every cycle can take a transfer
	assign busy   = 1'b0;
	assign in_vld = start && !busy;
	assign pready = 1'b1;

	// register index sits in address bit 2, only index zero exists
	assign reg_sel = (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_q <= MIN_NORM_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			min_norm_q <= pwdata;
		end
	end

	assign prdata = reg_sel ? min_norm_q : '0;

	// products, norms, threshold test and quadrant fold
	roa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (in_vld),
		.local_y    (local_y),
		.local_z    (local_z),
		.neighbor_y (neighbor_y),
		.neighbor_z (neighbor_z),
		.min_norm   (min_norm_q),
		.out        (chain[0])
	);

	// row of micro-rotation cells, cell g shifts by g and adds or subtracts atan(2^-g)
	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		roa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (CELL_IDX_W'(g)),
			.in     (chain[g]),
			.out    (chain[g+1])
		);
	end

	// 180 minus angle, wrap and round to 1/256 degree
	roa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in           (chain[NUM_CELLS]),
		.done         (done),
		.angle_deg_q8 (angle_deg_q8),
		.degenerate   (degenerate)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the relative orientation angle pipeline: a scoreboard
// predicts each angle from the four samples and the current threshold, and
// results are matched in order against the done strobe; the threshold is
// reprogrammed over apb between traffic phases, extremes included
// ----------------------------------------------------------------------------
module tb_top;
	import roa_pkg::*;

	// pipeline depth, used for the end wait
	localparam int PIPE_LATENCY   = NUM_CELLS + 5;
	// cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;

	// register map: min_norm_squared at index 0, index 1 has no register
	localparam logic [ADDR_W-1:0] ADDR_MIN_NORM = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_UNUSED   = ADDR_W'(4);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct {
		logic [OUT_W-1:0] angle;
		logic             degen;
	} angle_result_t;

	// ------------------------------------------------------------------------
	// scoreboard: predicts the angle of each accepted sample pair and matches
	// the results against the oldest pending prediction
	// ------------------------------------------------------------------------
	class angle_checker;
		logic [CFG_W-1:0] min_norm;
		angle_result_t    pending[$];
		int unsigned      mismatches;
		longint           arctan_q16[32];

		function new();
			min_norm   = MIN_NORM_RESET;
			mismatches = 0;
			// atan(2^-i) in 1/65536 degree
			arctan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
				2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		endfunction

		function angle_result_t predict_angle(sample_t ly_s, sample_t lz_s,
				sample_t ny_s, sample_t nz_s);
			angle_result_t r;
			longint ly, lz, ny, nz, norm_l, norm_n, thr, c, s, t, dx, dy, z, d, q;
			int i;
			ly  = ly_s;
			lz  = lz_s;
			ny  = ny_s;
			nz  = nz_s;
			thr = min_norm;
			norm_l = ly * ly + lz * lz;
			norm_n = ny * ny + nz * nz;
			if (norm_l < thr || norm_n < thr) begin
				r.angle = OUT_W'(46080);
				r.degen = 1'b1;
				return r;
			end
			c = -ly * ny + lz * nz;
			s = ly * nz + lz * ny;
			z = 0;
			// both zero: angle taken as 0
			if (c != 0 || s != 0) begin
				// pre-rotate into the right half plane
				if (c < 0) begin
					t = c;
					if (s >= 0) begin
						c = s;
						s = -t;
						z = 90 * 65536;
					end else begin
						c = -s;
						s = t;
						z = -90 * 65536;
					end
				end
				for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
					dx = s >>> i;
					dy = c >>> i;
					if (s > 0) begin
						c += dx;
						s -= dy;
						z += arctan_q16[i];
					end else begin
						c -= dx;
						s += dy;
						z -= arctan_q16[i];
					end
				end
			end
			// 180 minus angle, wrapped, then rounded half up to 1/256 degree
			d = (180 * 65536 - z) % (360 * 65536);
			if (d < 0)
				d += 360 * 65536;
			q = (d + 128) / 256;
			if (q >= 92160)
				q -= 92160;
			r.angle = OUT_W'(q);
			r.degen = 1'b0;
			return r;
		endfunction

		function void note_pair(sample_t ly, sample_t lz, sample_t ny, sample_t nz);
			pending.push_back(predict_angle(ly, lz, ny, nz));
		endfunction

		function void check_angle(logic [OUT_W-1:0] angle, logic degen);
			angle_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: angle_deg_q8 %0d degenerate %0b",
					$time, angle, degen);
				mismatches++;
				return;
			end
			exp_r = pending.pop_front();
			if (angle !== exp_r.angle) begin
				$display("%0t angle_deg_q8 mismatch: expected %0d, actual %0d",
					$time, exp_r.angle, angle);
				mismatches++;
			end
			if (degen !== exp_r.degen) begin
				$display("%0t degenerate mismatch: expected %0b, actual %0b",
					$time, exp_r.degen, degen);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block under test, every input known from time zero
	// ------------------------------------------------------------------------
	logic                clk;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic                busy;
	sample_t             local_y    = '0;
	sample_t             local_z    = '0;
	sample_t             neighbor_y = '0;
	sample_t             neighbor_z = '0;
	logic                done;
	logic [OUT_W-1:0]    angle_deg_q8;
	logic                degenerate;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [ADDR_W-1:0]   paddr      = '0;
	logic [CFG_W-1:0]    pwdata     = '0;
	logic [CFG_W-1:0]    prdata;
	logic                pready;

	relative_orientation_angle u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.local_y      (local_y),
		.local_z      (local_z),
		.neighbor_y   (neighbor_y),
		.neighbor_z   (neighbor_z),
		.done         (done),
		.angle_deg_q8 (angle_deg_q8),
		.degenerate   (degenerate),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	angle_checker sb = new();

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// monitor: inputs and results are sampled at the edge, before any driver
	// update of that edge lands, so the order of processes does not matter
	// ------------------------------------------------------------------------
	int unsigned stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pair(local_y, local_z, neighbor_y, neighbor_z);
			if (done)
				sb.check_angle(angle_deg_q8, degenerate);
			// watchdog: any transfer on either side counts as progress
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles", $time, stall_cycles);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender timing: mostly back to back or short gaps, a few long ones, and
	// now and then a burst with no gaps at all
	// ------------------------------------------------------------------------
	int unsigned burst_left = 0;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			burst_left = $urandom_range(20, 40);
			return 0;
		end else if (roll < 50) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// one command transfer; start stays high when no gap follows
	task automatic send_pair(int ly, int lz, int ny, int nz);
		int unsigned gap;
		start      <= 1'b1;
		local_y    <= sample_t'(ly);
		local_z    <= sample_t'(lz);
		neighbor_y <= sample_t'(ny);
		neighbor_z <= sample_t'(nz);
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every pending angle has come out
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// apb write, then a back-to-back read of the threshold to confirm it
	task automatic program_threshold(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_MIN_NORM)
			sb.min_norm = data;
		// read setup follows the write access directly, psel stays high
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_MIN_NORM;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.min_norm) begin
			$display("%0t min_norm_squared readback mismatch: expected %0d, actual %0d",
				$time, sb.min_norm, prdata);
			sb.mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// random sample sources
	// ------------------------------------------------------------------------
	function automatic int any_sample();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int small_sample(int unsigned radius);
		return int'($urandom_range(0, 2 * radius)) - int'(radius);
	endfunction

	function automatic int edge_sample();
		case ($urandom_range(0, 5))
			0:       return -32768;
			1:       return -32767;
			2:       return -1;
			3:       return 0;
			4:       return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic send_random_pair();
		int ly, lz, ny, nz;
		int unsigned mode, radius;
		ly   = any_sample();
		lz   = any_sample();
		ny   = any_sample();
		nz   = any_sample();
		mode = $urandom_range(0, 99);
		if (mode < 15) begin
			// small vectors, norms around the lower thresholds
			radius = $urandom_range(0, 1) ? $urandom_range(1, 50) : $urandom_range(51, 4000);
			ly = small_sample(radius);
			lz = small_sample(radius);
			ny = small_sample(radius);
			nz = small_sample(radius);
		end else if (mode < 27) begin
			// neighbor tied to local: lands on the axes and the 180 degree seam
			case ($urandom_range(0, 3))
				0: begin ny = ly;  nz = lz;  end
				1: begin ny = ly;  nz = -lz; end
				2: begin ny = -ly; nz = lz;  end
				default: begin ny = lz; nz = ly; end
			endcase
		end else if (mode < 37) begin
			ly = edge_sample();
			lz = edge_sample();
			ny = edge_sample();
			nz = edge_sample();
		end else if (mode < 42) begin
			// one vector zero
			if ($urandom_range(0, 1)) begin
				ly = 0;
				lz = 0;
			end else begin
				ny = 0;
				nz = 0;
			end
		end
		send_pair(ly, lz, ny, nz);
	endtask

	task automatic run_random(int unsigned count);
		repeat (count) begin
			// occasional full pause until the pipeline is empty
			if ($urandom_range(0, 59) == 0)
				drain_results();
			send_random_pair();
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, threshold at its reset value of 1
		send_pair(0, 0, 100, 200);               // local vector degenerate
		send_pair(100, 200, 0, 0);               // neighbor vector degenerate
		send_pair(1, 0, 0, 1);                   // norm equal to threshold, +90
		send_pair(0, 1, 0, 1);                   // angle 0, answer 180
		send_pair(0, 1, 0, -1);                  // cos < 0, sin = 0: wrap to 0
		send_pair(1, 0, 1, -1);                  // cos < 0, sin < 0
		send_pair(1, 0, 1, 1);                   // cos < 0, sin > 0
		send_pair(0, -1, 1, 0);                  // -90
		send_pair(-32768, -32768, -32768, -32768);
		send_pair(32767, 32767, 32767, 32767);
		send_pair(-32768, 32767, 32767, -32768);
		send_pair(32767, -32768, -32768, 32767);
		send_pair(-1, -1, -1, -1);
		send_pair(0, 32767, 0, -32768);
		send_pair(-32768, 0, 32767, 0);
		send_pair(12345, -23456, -31000, 777);

		// threshold 0: nothing degenerate, zero vectors reach the cordic
		drain_results();
		program_threshold(ADDR_MIN_NORM, 32'd0);
		send_pair(0, 0, 0, 0);                   // cos and sin both zero
		send_pair(0, 0, 5, -5);
		run_random(60);

		// top threshold: only the full-scale vector (-32768, -32768) passes
		drain_results();
		program_threshold(ADDR_MIN_NORM, 32'h8000_0000);
		send_pair(-32768, -32768, -32768, -32768);
		send_pair(-32768, -32768, 32767, 32767);
		run_random(50);

		// low threshold, plus a write to an unmapped index that must not land
		drain_results();
		program_threshold(ADDR_MIN_NORM, 32'd1000);
		program_threshold(ADDR_UNUSED, 32'd0);
		run_random(90);

		drain_results();
		program_threshold(ADDR_MIN_NORM, 32'd12345678);
		run_random(90);

		drain_results();
		program_threshold(ADDR_MIN_NORM, 32'd1);
		run_random(100);

		// let the pipeline empty, then watch for stray strobes
		drain_results();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("%0t %0d mismatches, %0d results missing", $time, sb.mismatches,
				sb.pending.size());
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/roa_pkg.sv
rtl/roa_front.sv
rtl/roa_cell.sv
rtl/roa_back.sv
rtl/relative_orientation_angle.sv
bench/tb_top.sv
